// ===== rtl/fcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared widths, codes and types of the feature correspondence matcher.
// ----------------------------------------------------------------------------
package fcm_pkg;

  localparam int REF_DEPTH_DEF = 256;

  localparam int POS_W      = 24;   // Q15.8 positions
  localparam int DIR_W      = 16;   // Q1.15 directions
  localparam int DIST_W     = 52;   // Q36.16 squared distance threshold
  localparam int ANG_W      = 33;   // Q3.30 dot product threshold
  localparam int IDX_W      = 8;    // result index field
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 52;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_THR = 8'd1;

  // Request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } fcm_entry_t;

  // One compare result leaving the match pipeline
  typedef struct packed {
    logic valid;
    logic hit;
  } fcm_res_t;

endpackage

// ===== rtl/fcm_ref_mem.sv =====
// ----------------------------------------------------------------------------
// fcm_ref_mem
// Reference feature store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcm_ref_mem #(
  parameter int REF_DEPTH = fcm_pkg::REF_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] wr_addr,
  input  fcm_pkg::fcm_entry_t    wr_data,
  input  logic                   rd_en,
  input  logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] rd_addr,
  output fcm_pkg::fcm_entry_t    rd_data
);
  import fcm_pkg::*;

  fcm_entry_t mem [REF_DEPTH];
  fcm_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fcm_match_dp.sv =====
// ----------------------------------------------------------------------------
// fcm_match_dp
// Match pipeline: difference, square/product, sum, threshold compare.
// ----------------------------------------------------------------------------
module fcm_match_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              issue,      // memory read issued
  input  logic                              flush,      // drop all in flight
  input  fcm_pkg::fcm_entry_t               query,
  input  fcm_pkg::fcm_entry_t               ref_entry,  // memory read data
  input  logic [fcm_pkg::DIST_W-1:0]        dist_thr,
  input  logic signed [fcm_pkg::ANG_W-1:0]  angle_thr,
  output fcm_pkg::fcm_res_t                 result
);
  import fcm_pkg::*;

  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * POS_W + 1;
  localparam int D2_W   = SQ_W + 2;
  localparam int PR_W   = 2 * DIR_W;
  localparam int DOT_W  = PR_W + 2;

  logic v0_r, v1_r, v2_r, v3_r;

  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIR_W-1:0]  rdx_r, rdy_r, rdz_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic signed [PR_W-1:0]   prx_r, pry_r, prz_r;
  logic [D2_W-1:0]          d2_r;
  logic signed [DOT_W-1:0]  dot_r;
  fcm_res_t                 res_r;

  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full, sqz_full;

  assign sqx_full = (2*DIFF_W)'(dx_r) * (2*DIFF_W)'(dx_r);
  assign sqy_full = (2*DIFF_W)'(dy_r) * (2*DIFF_W)'(dy_r);
  assign sqz_full = (2*DIFF_W)'(dz_r) * (2*DIFF_W)'(dz_r);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      res_r <= '0;
    end else begin
      v0_r      <= issue;
      v1_r      <= v0_r;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      res_r.valid <= v3_r;
      res_r.hit   <= ({1'b0, d2_r} < dist_thr) && (dot_r > DOT_W'(angle_thr));
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    dx_r  <= DIFF_W'(query.pos_x) - DIFF_W'(ref_entry.pos_x);
    dy_r  <= DIFF_W'(query.pos_y) - DIFF_W'(ref_entry.pos_y);
    dz_r  <= DIFF_W'(query.pos_z) - DIFF_W'(ref_entry.pos_z);
    rdx_r <= ref_entry.dir_x;
    rdy_r <= ref_entry.dir_y;
    rdz_r <= ref_entry.dir_z;

    sqx_r <= sqx_full[SQ_W-1:0];
    sqy_r <= sqy_full[SQ_W-1:0];
    sqz_r <= sqz_full[SQ_W-1:0];
    prx_r <= PR_W'(query.dir_x) * PR_W'(rdx_r);
    pry_r <= PR_W'(query.dir_y) * PR_W'(rdy_r);
    prz_r <= PR_W'(query.dir_z) * PR_W'(rdz_r);

    d2_r  <= D2_W'(sqx_r) + D2_W'(sqy_r) + D2_W'(sqz_r);
    dot_r <= DOT_W'(prx_r) + DOT_W'(pry_r) + DOT_W'(prz_r);
  end

  assign result = res_r;

endmodule

// ===== rtl/feature_correspondence_match_unit.sv =====
// ----------------------------------------------------------------------------
// feature_correspondence_match_unit
// Threshold first-match correspondence search over a stored feature set.
// ----------------------------------------------------------------------------
// A load transaction (req_type 0) appends one feature to the reference set,
// emptying the set first when new_set is high; loads into a full set are
// dropped and raise the sticky set_overflow flag, cleared only by reset. A
// query transaction (req_type 1) scans the stored entries in order, one entry
// read from the reference memory per cycle, through a compare pipeline of
// difference, square/product, sum and threshold compare stages, and returns
// the lowest matching index. A query ends sooner when a match is found early:
// the single memory read port sets the scan rate, and the pipeline depth adds
// to the time from acceptance to result. One transaction is worked on at a
// time; the result sits in an output register, so the next transaction is
// taken while a result waits for out_ready. Configuration writes take effect
// at once and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module feature_correspondence_match_unit #(
  parameter int REF_DEPTH = fcm_pkg::REF_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_req_type,
  input  logic                                  in_new_set,
  input  logic signed [fcm_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [fcm_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [fcm_pkg::POS_W-1:0]      in_pos_z,
  input  logic signed [fcm_pkg::DIR_W-1:0]      in_dir_x,
  input  logic signed [fcm_pkg::DIR_W-1:0]      in_dir_y,
  input  logic signed [fcm_pkg::DIR_W-1:0]      in_dir_z,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_match_found,
  output logic [fcm_pkg::IDX_W-1:0]             out_match_index,
  output logic                                  out_set_overflow,
  // Configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fcm_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import fcm_pkg::*;

  localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CW = $clog2(REF_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                   state_r;
  logic [CW-1:0]            count_r;        // stored entries
  logic                     overflow_r;
  logic [CW-1:0]            issue_cnt_r;    // next entry to read
  logic [CW-1:0]            res_cnt_r;      // compare results seen so far
  logic                     found_r;
  logic [IDX_W-1:0]         index_r;
  fcm_entry_t               query_r;
  logic [DIST_W-1:0]        dist_thr_r;
  logic signed [ANG_W-1:0]  angle_thr_r;

  logic                     out_valid_r;
  logic                     out_found_r;
  logic [IDX_W-1:0]         out_index_r;
  logic                     out_overflow_r;

  logic                     in_acc;
  logic                     load_acc;
  logic                     query_acc;
  logic [CW-1:0]            load_base;
  logic                     load_fits;
  logic                     wr_en;
  logic                     issue;
  logic                     hit;
  fcm_entry_t               in_entry;
  fcm_entry_t               rd_entry;
  fcm_res_t                 result;

  assign in_entry = '{pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
                      dir_x: in_dir_x, dir_y: in_dir_y, dir_z: in_dir_z};

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_acc  = in_acc && (in_req_type == REQ_LOAD);
  assign query_acc = in_acc && (in_req_type == REQ_QUERY);

  // new_set empties the set before the write, even when it was full
  assign load_base = in_new_set ? '0 : count_r;
  assign load_fits = (load_base < CW'(REF_DEPTH));
  assign wr_en     = load_acc && load_fits;

  // Scan: issue one read per cycle until all entries are out or a hit returns
  assign hit   = result.valid && result.hit;
  assign issue = (state_r == ST_SCAN) && (issue_cnt_r < count_r) && !hit;

  assign cfg_ready = 1'b1;

  fcm_ref_mem #(
    .REF_DEPTH (REF_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_base[AW-1:0]),
    .wr_data (in_entry),
    .rd_en   (issue),
    .rd_addr (issue_cnt_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  // A hit flushes the later, higher-index compares still in flight
  fcm_match_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .flush     (hit),
    .query     (query_r),
    .ref_entry (rd_entry),
    .dist_thr  (dist_thr_r),
    .angle_thr (angle_thr_r),
    .result    (result)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_thr_r  <= '0;
      angle_thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIST_THR:  dist_thr_r  <= cfg_data[DIST_W-1:0];
        CFG_ANGLE_THR: angle_thr_r <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // Query operands: hold for the whole scan
  always_ff @(posedge clk) begin
    if (query_acc) begin
      query_r <= in_entry;
    end
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      count_r        <= '0;
      overflow_r     <= 1'b0;
      issue_cnt_r    <= '0;
      res_cnt_r      <= '0;
      found_r        <= 1'b0;
      index_r        <= '0;
      out_valid_r    <= 1'b0;
      out_found_r    <= 1'b0;
      out_index_r    <= '0;
      out_overflow_r <= 1'b0;
    end else begin
      // Drop a result once taken; the emit arm refills the register itself
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (load_acc) begin
            if (load_fits) begin
              count_r <= load_base + CW'(1);
            end else begin
              count_r    <= load_base;
              overflow_r <= 1'b1;
            end
          end else if (query_acc) begin
            issue_cnt_r <= '0;
            res_cnt_r   <= '0;
            state_r     <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (issue) begin
            issue_cnt_r <= issue_cnt_r + CW'(1);
          end
          if (hit) begin
            // Results return in index order: this is the lowest match
            found_r <= 1'b1;
            index_r <= IDX_W'(res_cnt_r);
            state_r <= ST_EMIT;
          end else if (result.valid) begin
            res_cnt_r <= res_cnt_r + CW'(1);
          end else if (res_cnt_r == count_r) begin
            found_r <= 1'b0;
            index_r <= '0;
            state_r <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_found_r    <= found_r;
            out_index_r    <= index_r;
            out_overflow_r <= overflow_r;
            state_r        <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_found  = out_found_r;
  assign out_match_index  = out_index_r;
  assign out_set_overflow = out_overflow_r;

endmodule
